@@ sv/csv_field_delimiter_scanner_macros.svh @@
// Assertion macros shared by the CSV field delimiter scanner RTL.
// Self-contained; included by the files that carry concurrent assertions.
`ifndef CSV_FIELD_DELIMITER_SCANNER_MACROS_SVH
`define CSV_FIELD_DELIMITER_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSVFD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSVFD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/csvfd_pkg.sv @@
// Package for the CSV field delimiter scanner: byte codes, result type,
// register map and queue sizing. No dependencies.
`default_nettype none

package csvfd_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam int ROW_BITS      = 32;
    localparam int OUT_COL_BITS  = 16;
    localparam int OUT_POS_BITS  = 32;
    localparam int OUT_DATA_BITS = ROW_BITS + OUT_COL_BITS + 2 * OUT_POS_BITS;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic [APB_ADDR_BITS-1:0] REG_COLUMN_EVENTS = 3'd0;

    localparam int OUT_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [ROW_BITS-1:0]     row_number;
        logic [OUT_COL_BITS-1:0] column_index;
        logic [OUT_POS_BITS-1:0] start_position;
        logic [OUT_POS_BITS-1:0] end_position;
        logic                    quoted;
        logic                    last_in_row;
    } result_t;

endpackage

`default_nettype wire

@@ sv/csv_field_delimiter_scanner.sv @@
// A result item is registered in the result queue and offered on m_ once the results ahead of it are taken.
// Throughput: one input item per cycle while the result queue has room for two items;
// an item that yields two results (a held CR resolved together with a new column end)
// takes two entries of the four-entry result queue, which admits input only then.
// Reset (aresetn low, synchronous) clears scan state and queue and sets column_events.
`default_nettype none

`include "csv_field_delimiter_scanner_macros.svh"

module csv_field_delimiter_scanner import csvfd_pkg::*; #(
    parameter int POSITION_BITS     = 32,
    parameter int COLUMN_INDEX_BITS = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,   // [7:0] data_byte
    input  wire logic                     s_tlast,   // end_of_data
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // [31:0] row_number, [47:32] column_index, [79:48] start_position,
    // [111:80] end_position
    output logic [OUT_DATA_BITS-1:0]      m_tdata,
    output logic [0:0]                    m_tuser,   // [0] quoted
    output logic                          m_tlast,   // last_in_row
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0]      prdata,
    output logic                          pready
);

    localparam int PB = POSITION_BITS;
    localparam int CB = COLUMN_INDEX_BITS;

    logic                column_events_reg;
    logic                inside_quote_reg, inside_quote_next;
    logic                after_newline_reg, after_newline_next;
    logic                quote_seen_reg, quote_seen_next;
    logic                cr_pending_reg, cr_pending_next;
    logic [PB-1:0]       byte_position_reg, byte_position_next;
    logic [PB-1:0]       column_start_reg, column_start_next;
    logic [CB-1:0]       column_counter_reg, column_counter_next;
    logic [ROW_BITS-1:0] rows_ended_reg, rows_ended_next;

    logic                s_accept;
    logic                cfg_write;
    logic [7:0]          data_byte;
    logic                quote_hit, comma_hit, is_lf, is_cr;
    logic                cr_flush, comma_end, row_end, event_b;
    logic [ROW_BITS-1:0] rows_mid;
    logic [CB-1:0]       col_mid;
    logic [PB-1:0]       start_mid;
    logic                quote_mid;
    logic [PB-1:0]       pos_plus1;
    result_t             res_a, res_b, push0, out_item;
    logic [1:0]          push_count;
    logic                room_for_two;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == REG_COLUMN_EVENTS)
                       ? {{(APB_DATA_BITS-1){1'b0}}, column_events_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_events_reg <= 1'b1;
        end else if (cfg_write && paddr == REG_COLUMN_EVENTS) begin
            column_events_reg <= pwdata[0];
        end
    end

    assign s_tready  = room_for_two;
    assign s_accept  = s_tvalid && s_tready;
    assign data_byte = s_tdata;

    always_comb begin
        quote_hit = (data_byte == CH_QUOTE);
        comma_hit = (data_byte == CH_COMMA);
        is_lf    = (data_byte == CH_LF);
        is_cr    = (data_byte == CH_CR);
        pos_plus1 = byte_position_reg + PB'(1);

        // A held CR that is not followed by LF closes the row at the CR.
        cr_flush  = cr_pending_reg && !is_lf;
        rows_mid  = rows_ended_reg + ROW_BITS'(cr_flush);
        col_mid   = cr_flush ? '0 : column_counter_reg;
        start_mid = cr_flush ? byte_position_reg : column_start_reg;
        quote_mid = cr_flush ? 1'b0 : quote_seen_reg;

        res_a.row_number     = rows_mid;
        res_a.column_index   = OUT_COL_BITS'(column_counter_reg);
        res_a.start_position = OUT_POS_BITS'(column_start_reg);
        res_a.end_position   = OUT_POS_BITS'(byte_position_reg - PB'(1));
        res_a.quoted         = quote_seen_reg;
        res_a.last_in_row    = 1'b1;

        comma_end = !quote_hit && !inside_quote_reg && comma_hit;
        row_end   = !quote_hit && !inside_quote_reg && (is_lf || (is_cr && s_tlast));
        event_b   = row_end || (comma_end && column_events_reg);

        res_b.row_number     = rows_mid + ROW_BITS'(row_end);
        res_b.column_index   = OUT_COL_BITS'(col_mid);
        res_b.start_position = OUT_POS_BITS'(start_mid);
        res_b.end_position   = OUT_POS_BITS'(byte_position_reg);
        res_b.quoted         = quote_mid;
        res_b.last_in_row    = row_end;

        inside_quote_next  = quote_hit ? (!inside_quote_reg && after_newline_reg)
                                       : inside_quote_reg;
        after_newline_next = !quote_hit && (is_lf || is_cr);
        cr_pending_next    = !quote_hit && !inside_quote_reg && is_cr && !s_tlast;
        rows_ended_next    = rows_mid + ROW_BITS'(row_end);
        byte_position_next = pos_plus1;

        if (quote_hit) begin
            quote_seen_next = 1'b1;
        end else if (comma_end || row_end) begin
            quote_seen_next = 1'b0;
        end else begin
            quote_seen_next = quote_mid;
        end

        if (row_end) begin
            column_counter_next = '0;
        end else if (comma_end && col_mid != {CB{1'b1}}) begin
            column_counter_next = col_mid + CB'(1);
        end else begin
            column_counter_next = col_mid;
        end

        column_start_next = (comma_end || row_end) ? pos_plus1 : start_mid;

        if (s_accept) begin
            push_count = 2'({1'b0, cr_flush}) + 2'({1'b0, event_b});
        end else begin
            push_count = 2'd0;
        end
        push0 = cr_flush ? res_a : res_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_quote_reg   <= 1'b0;
            after_newline_reg  <= 1'b1;
            quote_seen_reg     <= 1'b0;
            cr_pending_reg     <= 1'b0;
            byte_position_reg  <= '0;
            column_start_reg   <= '0;
            column_counter_reg <= '0;
            rows_ended_reg     <= '0;
        end else if (s_accept) begin
            inside_quote_reg   <= inside_quote_next;
            after_newline_reg  <= after_newline_next;
            quote_seen_reg     <= quote_seen_next;
            cr_pending_reg     <= cr_pending_next;
            byte_position_reg  <= byte_position_next;
            column_start_reg   <= column_start_next;
            column_counter_reg <= column_counter_next;
            rows_ended_reg     <= rows_ended_next;
        end
    end

    csvfd_result_fifo #(
        .DEPTH(OUT_QUEUE_DEPTH)
    ) u_result_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_count  (push_count),
        .push_data0  (push0),
        .push_data1  (res_b),
        .room_for_two(room_for_two),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (out_item)
    );

    assign m_tdata = {out_item.end_position, out_item.start_position,
                      out_item.column_index, out_item.row_number};
    assign m_tuser = out_item.quoted;
    assign m_tlast = out_item.last_in_row;

    `CSVFD_ASSERT_IMP(a_cr_implies_newline, aclk, aresetn, cr_pending_reg, after_newline_reg, "held CR without newline state")
    `CSVFD_ASSERT_IMP(a_cr_outside_quote, aclk, aresetn, cr_pending_reg, !inside_quote_reg, "held CR inside a quoted region")
    `CSVFD_ASSERT_NXT(a_lf_gives_result, aclk, aresetn, s_accept && is_lf && !inside_quote_reg, m_tvalid, "row end produced no result")

endmodule

`default_nettype wire

@@ sv/csvfd_result_fifo.sv @@
// Small result queue for the CSV field delimiter scanner: takes up to two
// items per cycle and hands out one. Depends on csvfd_pkg.
`default_nettype none

module csvfd_result_fifo import csvfd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic [1:0] push_count,
    input  wire result_t push_data0,
    input  wire result_t push_data1,
    output logic         room_for_two,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    result_t              entry_reg [DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [PTR_BITS-1:0]  wr_ptr_plus1;
    logic                 pop;

    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_data     = entry_reg[rd_ptr_reg];
    assign room_for_two = (count_reg <= CNT_BITS'(DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_BITS'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(push_count) - CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_count == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= push_data1;
        end
    end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Testbench for csv_field_delimiter_scanner: drives CSV bytes, predicts column ends.
// Depends on csvfd_pkg for byte codes, the result type and the register map.

module tb import csvfd_pkg::*; ();

    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_ITEMS = 350;
    localparam int HOLD_CYCLES = 300;

    class column_end_tracker;
        bit        report_columns;
        bit        in_quotes;
        bit        after_row_end;
        bit        quote_in_column;
        bit        cr_held;
        bit [31:0] position;
        bit [31:0] col_start;
        bit [31:0] rows;
        bit [15:0] col_count;
        result_t   expected_columns[$];
        int        mismatches;

        function new();
            report_columns = 1'b1;
            after_row_end = 1'b1;
        endfunction

        function int pending();
            return expected_columns.size();
        endfunction

        function void flag(string msg);
            if (mismatches < 10) $display("%0t mismatch: %s", $realtime, msg);
            mismatches++;
        endfunction

        function void push_column(bit [31:0] end_pos, bit last);
            result_t r;
            r.row_number = rows;
            r.column_index = col_count;
            r.start_position = col_start;
            r.end_position = end_pos;
            r.quoted = quote_in_column;
            r.last_in_row = last;
            expected_columns.push_back(r);
        endfunction

        function void close_row(bit [31:0] end_pos);
            rows++;
            push_column(end_pos, 1'b1);
            col_count = '0;
            quote_in_column = 1'b0;
            col_start = end_pos + 1;
        endfunction

        function void note_byte(logic [7:0] b, logic eod);
            bit [31:0] pos;
            pos = position;
            if (cr_held) begin
                cr_held = 1'b0;
                if (b != CH_LF) close_row(pos - 1);
            end
            if (b == CH_QUOTE) begin
                quote_in_column = 1'b1;
                if (in_quotes) in_quotes = 1'b0;
                else if (after_row_end) in_quotes = 1'b1;
                after_row_end = 1'b0;
            end else if (in_quotes) begin
                after_row_end = (b == CH_LF || b == CH_CR);
            end else if (b == CH_COMMA) begin
                if (report_columns) push_column(pos, 1'b0);
                if (col_count != '1) col_count++;
                quote_in_column = 1'b0;
                col_start = pos + 1;
                after_row_end = 1'b0;
            end else if (b == CH_LF) begin
                close_row(pos);
                after_row_end = 1'b1;
            end else if (b == CH_CR) begin
                if (eod) close_row(pos);
                else cr_held = 1'b1;
                after_row_end = 1'b1;
            end else begin
                after_row_end = 1'b0;
            end
            position = pos + 1;
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (expected_columns.size() == 0) begin
                flag($sformatf("unexpected result row %0d col %0d start %0d end %0d",
                     got.row_number, got.column_index, got.start_position,
                     got.end_position));
                return;
            end
            exp = expected_columns.pop_front();
            if (got.row_number !== exp.row_number || got.column_index !== exp.column_index ||
                got.start_position !== exp.start_position ||
                got.end_position !== exp.end_position || got.quoted !== exp.quoted ||
                got.last_in_row !== exp.last_in_row)
                flag($sformatf({"expected row %0d col %0d start %0d end %0d q %0d last %0d, ",
                     "got row %0d col %0d start %0d end %0d q %0d last %0d"},
                     exp.row_number, exp.column_index, exp.start_position,
                     exp.end_position, exp.quoted, exp.last_in_row,
                     got.row_number, got.column_index, got.start_position,
                     got.end_position, got.quoted, got.last_in_row));
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [7:0]               s_tdata = '0;
    logic                     s_tlast = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic [0:0]               m_tuser;
    logic                     m_tlast;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    column_end_tracker board;
    int send_idle_pct = 0;
    int ready_stall_pct = 0;
    int items_sent = 0;
    int stall_count = 0;
    bit hold_request = 1'b0;

    csv_field_delimiter_scanner uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        result_t got;
        if (aresetn && s_tvalid && s_tready) board.note_byte(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) begin
            got.row_number = m_tdata[31:0];
            got.column_index = m_tdata[47:32];
            got.start_position = m_tdata[79:48];
            got.end_position = m_tdata[111:80];
            got.quoted = m_tuser[0];
            got.last_in_row = m_tlast;
            board.check_result(got);
        end
    end

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= ready_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            stall_count <= 0;
        else if (s_tvalid || board.pending() != 0)
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic eod);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eod;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_column_events(input bit value);
        logic [APB_DATA_BITS-1:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_COLUMN_EVENTS;
        pwdata <= {{(APB_DATA_BITS-1){1'b0}}, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.report_columns = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== {{(APB_DATA_BITS-1){1'b0}}, value})
            board.flag($sformatf("column_events reads %0h, expected %0h", readback, value));
    endtask

    function automatic logic random_eod();
        return ($urandom_range(29) == 0);
    endfunction

    function automatic logic [7:0] plain_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80) return 8'(8'h61 + $urandom_range(25));
        if (pick < 86) return CH_QUOTE;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] quoted_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) return 8'(8'h41 + $urandom_range(25));
        if (pick < 70) return CH_COMMA;
        if (pick < 80) return CH_LF;
        if (pick < 90) return CH_CR;
        if (pick < 95) return CH_QUOTE;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_row();
        int fields;
        fields = $urandom_range(1, 5);
        for (int f = 0; f < fields; f++) begin
            if (f == 0 && $urandom_range(2) == 0) begin
                send_item(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 6)) send_item(quoted_byte(), random_eod());
                send_item(CH_QUOTE, 1'b0);
            end else begin
                repeat ($urandom_range(0, 6)) send_item(plain_byte(), random_eod());
            end
            if (f != fields - 1) send_item(CH_COMMA, random_eod());
        end
        case ($urandom_range(2))
            0: send_item(CH_LF, random_eod());
            1: send_item(CH_CR, $urandom_range(3) == 0);
            default: begin
                send_item(CH_CR, 1'b0);
                send_item(CH_LF, random_eod());
            end
        endcase
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input bit events,
                             input bit pressure);
        int target;
        bit held;
        bit paused;
        set_column_events(events);
        send_idle_pct = idle_pct;
        ready_stall_pct = stall_pct;
        target = items_sent + PHASE_ITEMS;
        held = 1'b0;
        paused = 1'b0;
        while (items_sent < target) begin
            if (pressure && !held && items_sent > target - PHASE_ITEMS / 2) begin
                hold_request = 1'b1;
                held = 1'b1;
            end
            if (pressure && !paused && items_sent > target - PHASE_ITEMS / 4) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 8)) send_item(8'($urandom_range(255)), random_eod());
            else
                send_row();
        end
        wait_drained();
    endtask

    initial begin
        board = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Quoted first column holding a comma and a newline, then extreme bytes.
        send_item(CH_QUOTE, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(CH_COMMA, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_COMMA, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        // A held CR resolved by a comma gives two results from one item.
        send_item(CH_CR, 1'b0);
        send_item(CH_COMMA, 1'b0);
        send_item(8'h62, 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(8'h78, 1'b1);
        send_item(CH_CR, 1'b1);
        send_item(CH_CR, 1'b0);
        send_item(CH_CR, 1'b0);
        send_item(8'h71, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(CH_LF, 1'b0);
        wait_drained();

        // Row counting mode, with commas that advance the column index silently.
        set_column_events(1'b0);
        send_item(CH_COMMA, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_LF, 1'b0);
        repeat (40) send_item(CH_COMMA, 1'b0);
        send_item(CH_LF, 1'b0);
        wait_drained();

        run_phase(0, 0, 1'b1, 1'b1);
        run_phase(69, 0, 1'b0, 1'b0);
        run_phase(0, 69, 1'b1, 1'b0);
        run_phase(14, 14, 1'b0, 1'b0);
        run_phase(14, 14, 1'b1, 1'b0);
        repeat (8) @(posedge aclk);

        if (board.mismatches == 0 && board.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
